>>> sv/kpew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpew_pkg: shared types and constants
// Fixed output widths, CORDIC arctangent table, internal status struct.
// ----------------------------------------------------------------------------
package kpew_pkg;

	localparam int ANGLE_W    = 15;
	localparam int DIST_W     = 25;
	localparam int WEIGHT_W   = 39;
	localparam int CORDIC_N   = 22;
	localparam int STEP_W     = 5;
	localparam int ZACC_W     = 24;
	localparam int CS_W       = 34;
	localparam int TRACE_W    = 40;

	localparam logic [ANGLE_W-1:0]  ANGLE_MAX    = 15'd23040;
	localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = {WEIGHT_W{1'b1}};
	localparam logic [ZACC_W-1:0]   QUARTER_TURN = 24'd2949120;

	// atan(2^-i) in 2^-15 degree
	function automatic logic [ZACC_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [ZACC_W-1:0] v;
		begin
			case (i)
				5'd0:  v = 24'd1474560;
				5'd1:  v = 24'd870484;
				5'd2:  v = 24'd459940;
				5'd3:  v = 24'd233473;
				5'd4:  v = 24'd117189;
				5'd5:  v = 24'd58652;
				5'd6:  v = 24'd29333;
				5'd7:  v = 24'd14667;
				5'd8:  v = 24'd7334;
				5'd9:  v = 24'd3667;
				5'd10: v = 24'd1833;
				5'd11: v = 24'd917;
				5'd12: v = 24'd458;
				5'd13: v = 24'd229;
				5'd14: v = 24'd115;
				5'd15: v = 24'd57;
				5'd16: v = 24'd29;
				5'd17: v = 24'd14;
				5'd18: v = 24'd7;
				5'd19: v = 24'd4;
				5'd20: v = 24'd2;
				5'd21: v = 24'd1;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} ctl_t;

endpackage

>>> sv/kpew_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpew_if: valid/ready channels
// Pose input channel and result output channel.
// ----------------------------------------------------------------------------
interface kpew_pose_if #(
	parameter int ROT_WIDTH = 16,
	parameter int POS_WIDTH = 24
);
	logic                        valid;
	logic                        ready;
	logic                        chain_start;
	logic signed [ROT_WIDTH-1:0] rot_r0c0;
	logic signed [ROT_WIDTH-1:0] rot_r0c1;
	logic signed [ROT_WIDTH-1:0] rot_r0c2;
	logic signed [ROT_WIDTH-1:0] rot_r1c0;
	logic signed [ROT_WIDTH-1:0] rot_r1c1;
	logic signed [ROT_WIDTH-1:0] rot_r1c2;
	logic signed [ROT_WIDTH-1:0] rot_r2c0;
	logic signed [ROT_WIDTH-1:0] rot_r2c1;
	logic signed [ROT_WIDTH-1:0] rot_r2c2;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_z;

	modport source (output valid, chain_start, rot_r0c0, rot_r0c1, rot_r0c2,
		rot_r1c0, rot_r1c1, rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_z,
		input ready);
	modport sink (input valid, chain_start, rot_r0c0, rot_r0c1, rot_r0c2,
		rot_r1c0, rot_r1c1, rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_z,
		output ready);
endinterface

interface kpew_edge_if;
	logic                          valid;
	logic                          ready;
	logic [kpew_pkg::ANGLE_W-1:0]  angle_deg;
	logic [kpew_pkg::DIST_W-1:0]   distance_mm;
	logic [kpew_pkg::WEIGHT_W-1:0] edge_weight;

	modport source (output valid, angle_deg, distance_mm, edge_weight, input ready);
	modport sink (input valid, angle_deg, distance_mm, edge_weight, output ready);
endinterface

>>> sv/kpew_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpew_isqrt: digit-serial integer square root
// Restoring method, one result bit per cycle; floor(sqrt(n)).
// ----------------------------------------------------------------------------
module kpew_isqrt #(
	parameter int IN_W = 58
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     radicand,
	output kpew_pkg::ctl_t      ctl,
	output logic [IN_W/2-1:0]   root
);
	localparam int R_W   = IN_W / 2 + ((IN_W % 2) != 0 ? 1 : 0);
	localparam int N_W   = 2 * R_W;
	localparam int REM_W = R_W + 2;
	localparam int CNT_W = $clog2(R_W + 1);

	logic [N_W-1:0]   n_q;
	logic [REM_W-1:0] rem_q;
	logic [R_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;

	assign rem_sh = {rem_q[REM_W-3:0], n_q[N_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(R_W);
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= N_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[N_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[R_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[R_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign root      = root_q[IN_W/2-1:0];

endmodule

>>> sv/keyframe_pair_edge_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_pair_edge_weight: relative angle, x/z distance and edge weight
// between consecutive keyframe poses.
// ----------------------------------------------------------------------------
// channel | dir | handshake     | payload
// pose    | in  | valid/ready   | chain_start, rot_r0c0..rot_r2c2, pos_x, pos_z
// edge    | out | valid/ready   | angle_deg, distance_mm, edge_weight
//
// One item at a time. A chain-start pose (or any pose with no stored one)
// is stored at the accepting edge and gives no result. Otherwise, from the
// accepting edge: trace accumulation (one product per cycle), a setup state,
// the 30-bit sine-term square root (start, one root bit a cycle, done) that
// hides the 26-bit distance square root, 22 CORDIC steps, a rounding state,
// the shift-add multiply for the weight and the output load, after which the
// edge item is valid. arst_n clears the stored-pose flag and the control;
// stored poses are not cleared. A stalled edge item is held in the output
// register; the next pose is taken the cycle after it has left.
// ----------------------------------------------------------------------------
module keyframe_pair_edge_weight #(
	parameter int ROT_WIDTH = 16,
	parameter int POS_WIDTH = 24
) (
	input logic clk,
	input logic arst_n,
	kpew_pose_if.sink   pose,
	kpew_edge_if.source edge_o
);
	localparam int SH     = 2 * (ROT_WIDTH - 2) - 28;
	localparam int PROD_W = 2 * ROT_WIDTH;
	localparam int DX_W   = POS_WIDTH + 1;
	localparam int SQ_W   = 52;
	localparam int CS_W   = kpew_pkg::CS_W;
	localparam int TR_W   = kpew_pkg::TRACE_W;
	localparam int Z_W    = kpew_pkg::ZACC_W + 2;
	localparam int MW     = kpew_pkg::WEIGHT_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TRACE, ST_SQ, ST_ROOT, ST_CORDIC, ST_ROUND, ST_MUL, ST_OUT
	} state_t;

	state_t state_q;
	logic   have_prev_q;

	logic signed [ROT_WIDTH-1:0] prev_rot_q [9];
	logic signed [ROT_WIDTH-1:0] cur_rot_q  [9];
	logic signed [POS_WIDTH-1:0] prev_x_q, prev_z_q;
	logic signed [DX_W-1:0]      dx_q, dz_q;
	logic [3:0]                  idx_q;
	logic signed [TR_W-1:0]      trace_q;
	logic signed [CS_W-1:0]      c_q, x_q, y_q;
	logic signed [Z_W-1:0]       z_q;
	logic [kpew_pkg::STEP_W-1:0] step_q;
	logic [SQ_W-1:0]             dsq_q;
	logic                        dsat_q;
	logic [kpew_pkg::ANGLE_W-1:0]  ang_q;
	logic [kpew_pkg::DIST_W-1:0]   dist_q;
	logic [MW-1:0]                 acc_q;
	logic [kpew_pkg::ANGLE_W-1:0]  mplr_q;
	logic [kpew_pkg::ANGLE_W-1:0]  ang_out_q;
	logic [kpew_pkg::DIST_W-1:0]   dist_out_q;
	logic [kpew_pkg::WEIGHT_W-1:0] wt_out_q;
	logic                          out_valid_q;
	logic                          s_start_q, d_start_q;

	logic [3:0] rot_idx;
	assign rot_idx = (idx_q > 4'd8) ? 4'd0 : idx_q;

	// one product per cycle
	logic signed [PROD_W-1:0] prod;
	logic signed [TR_W-1:0]   prod_q28;
	assign prod = PROD_W'(cur_rot_q[rot_idx]) * PROD_W'(prev_rot_q[rot_idx]);
	generate
		if (SH >= 0) begin : g_shr
			assign prod_q28 = TR_W'(prod >>> SH);
		end else begin : g_shl
			assign prod_q28 = TR_W'(prod) <<< (-SH);
		end
	endgenerate

	// clamp and c = t - 2^28
	logic signed [TR_W-1:0] t_cl;
	logic signed [CS_W-1:0] c_val;
	logic [CS_W-1:0]        c_abs;
	always_comb begin
		t_cl = trace_q;
		if (trace_q > TR_W'(64'sd805306368))
			t_cl = TR_W'(64'sd805306368);
		if (trace_q < -TR_W'(64'sd268435456))
			t_cl = -TR_W'(64'sd268435456);
	end
	assign c_val = CS_W'(t_cl - TR_W'(64'sd268435456));
	assign c_abs = c_val[CS_W-1] ? CS_W'(-c_val) : c_val;

	// c^2, 30x30; 2^58 - c^2 reaches 2^58 at c = 0
	logic [59:0] csq;
	logic [59:0] s_rad;
	assign csq   = 60'(c_abs[29:0]) * 60'(c_abs[29:0]);
	assign s_rad = (60'd1 << 58) - csq;

	logic [59:0] s_rad_q;
	kpew_pkg::ctl_t s_ctl, d_ctl;
	logic [29:0] s_root;
	logic [25:0] d_root;

	kpew_isqrt #(.IN_W(60)) u_ssqrt (
		.clk(clk), .arst_n(arst_n), .start(s_start_q), .radicand(s_rad_q),
		.ctl(s_ctl), .root(s_root));

	kpew_isqrt #(.IN_W(SQ_W)) u_dsqrt (
		.clk(clk), .arst_n(arst_n), .start(d_start_q), .radicand(dsq_q),
		.ctl(d_ctl), .root(d_root));

	logic d_done_q;

	// distance inputs
	logic [DX_W-1:0] ax, az;
	assign ax = dx_q[DX_W-1] ? DX_W'(-dx_q) : DX_W'(dx_q);
	assign az = dz_q[DX_W-1] ? DX_W'(-dz_q) : DX_W'(dz_q);
	logic [31:0] ax32, az32;
	assign ax32 = 32'(ax);
	assign az32 = 32'(az);
	logic ovf;
	assign ovf = (ax32 >= 32'd33554432) || (az32 >= 32'd33554432);

	// CORDIC step
	logic signed [CS_W-1:0] xs, ys;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	// rounding
	logic signed [Z_W-1:0] z_pos;
	logic [Z_W-1:0]        z_rnd;
	assign z_pos = z_q[Z_W-1] ? '0 : z_q;
	assign z_rnd = (Z_W'(z_pos) + Z_W'(128)) >> 8;

	logic [31:0] dist_full;
	assign dist_full = 32'(d_root);

	logic in_fire;
	assign pose.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire    = pose.valid && pose.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			s_start_q   <= 1'b0;
			d_start_q   <= 1'b0;
			d_done_q    <= 1'b0;
			idx_q       <= '0;
			step_q      <= '0;
		end else begin
			s_start_q <= 1'b0;
			d_start_q <= 1'b0;
			if (d_ctl.done)
				d_done_q <= 1'b1;
			if (out_valid_q && edge_o.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						have_prev_q <= 1'b1;
						if (!pose.chain_start && have_prev_q) begin
							state_q <= ST_TRACE;
							idx_q   <= '0;
						end
					end
				end
				ST_TRACE: begin
					if (idx_q == 4'd8) begin
						state_q <= ST_SQ;
					end
					idx_q <= idx_q + 4'd1;
				end
				ST_SQ: begin
					s_start_q <= 1'b1;
					d_start_q <= !ovf;
					d_done_q  <= ovf;
					state_q   <= ST_ROOT;
				end
				ST_ROOT: begin
					if (s_ctl.done) begin
						state_q <= ST_CORDIC;
						step_q  <= '0;
					end
				end
				ST_CORDIC: begin
					if (step_q == kpew_pkg::STEP_W'(kpew_pkg::CORDIC_N - 1))
						state_q <= ST_ROUND;
					step_q <= step_q + 1'b1;
				end
				ST_ROUND: begin
					if (d_done_q || d_ctl.done) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == kpew_pkg::STEP_W'(kpew_pkg::ANGLE_W - 1))
						state_q <= ST_OUT;
					step_q <= step_q + 1'b1;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prev_rot_q[0] <= pose.rot_r0c0; prev_rot_q[1] <= pose.rot_r0c1;
			prev_rot_q[2] <= pose.rot_r0c2; prev_rot_q[3] <= pose.rot_r1c0;
			prev_rot_q[4] <= pose.rot_r1c1; prev_rot_q[5] <= pose.rot_r1c2;
			prev_rot_q[6] <= pose.rot_r2c0; prev_rot_q[7] <= pose.rot_r2c1;
			prev_rot_q[8] <= pose.rot_r2c2;
			cur_rot_q[0] <= have_prev_q ? prev_rot_q[0] : '0;
			cur_rot_q[1] <= have_prev_q ? prev_rot_q[1] : '0;
			cur_rot_q[2] <= have_prev_q ? prev_rot_q[2] : '0;
			cur_rot_q[3] <= have_prev_q ? prev_rot_q[3] : '0;
			cur_rot_q[4] <= have_prev_q ? prev_rot_q[4] : '0;
			cur_rot_q[5] <= have_prev_q ? prev_rot_q[5] : '0;
			cur_rot_q[6] <= have_prev_q ? prev_rot_q[6] : '0;
			cur_rot_q[7] <= have_prev_q ? prev_rot_q[7] : '0;
			cur_rot_q[8] <= have_prev_q ? prev_rot_q[8] : '0;
			prev_x_q <= pose.pos_x;
			prev_z_q <= pose.pos_z;
			dx_q     <= DX_W'(pose.pos_x) - DX_W'(prev_x_q);
			dz_q     <= DX_W'(pose.pos_z) - DX_W'(prev_z_q);
			trace_q  <= '0;
		end
		case (state_q)
			ST_TRACE: trace_q <= trace_q + prod_q28;
			ST_SQ: begin
				s_rad_q <= s_rad;
				c_q     <= c_val;
				dsat_q  <= ovf;
				dsq_q   <= SQ_W'(ax32[25:0]) * SQ_W'(ax32[25:0])
					+ SQ_W'(az32[25:0]) * SQ_W'(az32[25:0]);
			end
			ST_ROOT: begin
				if (s_ctl.done) begin
					if (c_q[CS_W-1]) begin
						x_q <= CS_W'(s_root);
						y_q <= -c_q;
						z_q <= Z_W'(kpew_pkg::QUARTER_TURN);
					end else begin
						x_q <= c_q;
						y_q <= CS_W'(s_root);
						z_q <= '0;
					end
				end
			end
			ST_CORDIC: begin
				if (!y_q[CS_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + Z_W'(kpew_pkg::atan_lut(step_q));
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - Z_W'(kpew_pkg::atan_lut(step_q));
				end
			end
			ST_ROUND: begin
				ang_q  <= (z_rnd > Z_W'(kpew_pkg::ANGLE_MAX)) ? kpew_pkg::ANGLE_MAX
					: kpew_pkg::ANGLE_W'(z_rnd);
				mplr_q <= (z_rnd > Z_W'(kpew_pkg::ANGLE_MAX)) ? kpew_pkg::ANGLE_MAX
					: kpew_pkg::ANGLE_W'(z_rnd);
				dist_q <= (dsat_q || dist_full > 32'(kpew_pkg::DIST_MAX))
					? kpew_pkg::DIST_MAX : kpew_pkg::DIST_W'(dist_full);
				acc_q  <= '0;
			end
			ST_MUL: begin
				// shift-add, multiplier MSB first
				acc_q  <= (acc_q << 1) + (mplr_q[kpew_pkg::ANGLE_W-1] ? MW'(dist_q) : '0);
				mplr_q <= mplr_q << 1;
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					ang_out_q  <= ang_q;
					dist_out_q <= dist_q;
					wt_out_q   <= acc_q[MW-1] ? kpew_pkg::WEIGHT_MAX
						: acc_q[kpew_pkg::WEIGHT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign edge_o.valid       = out_valid_q;
	assign edge_o.angle_deg   = ang_out_q;
	assign edge_o.distance_mm = dist_out_q;
	assign edge_o.edge_weight = wt_out_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pose.ready) else $error("pose taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !edge_o.ready) |=> out_valid_q) else $error("edge item dropped");
	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ang_out_q <= kpew_pkg::ANGLE_MAX)) else $error("angle over range");

endmodule
